// ===== hdl/erfg_pkg.sv =====
package erfg_pkg;

  localparam int unsigned CountW = 32;
  localparam int unsigned IdW    = 64;
  localparam int unsigned ScanW  = 8;

  localparam logic [ScanW-1:0] NeededScansReset = 8'd1;

  typedef enum logic [1:0] {
    ACT_LOCAL   = 2'd0,
    ACT_BACKEND = 2'd1,
    ACT_SCAN    = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    R_INITIAL       = 3'd0,
    R_SAME          = 3'd1,
    R_STALE_LOCAL   = 3'd2,
    R_LOCAL_CHANGED = 3'd3,
    R_NOT_APPLIED   = 3'd4,
    R_STALE_BACKEND = 3'd5,
    R_BACKEND_OK    = 3'd6,
    R_SCAN          = 3'd7
  } reason_t;

  typedef struct packed {
    logic [1:0]        action;
    logic [CountW-1:0] reset_count;
    logic [IdW-1:0]    session;
    logic [IdW-1:0]    transaction;
    logic              was_applied;
    logic              scan_healthy;
  } item_t;

  typedef struct packed {
    logic              accepted;
    logic              reseed_started;
    logic              fail_open;
    reason_t           reason;
    logic              reseed_done;
    logic [CountW-1:0] ignored_total;
    logic [CountW-1:0] backend_total;
  } result_t;

  // stage handshake between pipeline registers
  typedef struct packed {
    logic valid;
    logic take;
  } stage_ctl_t;

endpackage

// ===== hdl/erfg_in_stage.sv =====
module erfg_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  erfg_pkg::item_t in_item,
  input  logic            take,
  output erfg_pkg::stage_ctl_t ctl,
  output erfg_pkg::item_t item
);
  import erfg_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r;

  // accept when empty or when the held item leaves this cycle
  assign in_ready  = !valid_r || take;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign ctl.valid = valid_r;
  assign ctl.take  = take;
  assign item      = item_r;

endmodule

// ===== hdl/erfg_core.sv =====
module erfg_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [7:0]        cfg_wr_data,
  input  erfg_pkg::stage_ctl_t ctl,
  input  erfg_pkg::item_t   item,
  output erfg_pkg::result_t res
);
  import erfg_pkg::*;

  logic              fire;
  logic [ScanW-1:0]  needed_r;
  logic              local_seen_r, local_seen_nxt;
  logic [CountW-1:0] local_counter_r, local_counter_nxt;
  logic              reseeding_r, reseeding_nxt;
  logic [ScanW-1:0]  scan_cnt_r, scan_cnt_nxt;
  logic              backend_seen_r, backend_seen_nxt;
  logic [IdW-1:0]    last_session_r, last_session_nxt;
  logic [IdW-1:0]    last_trans_r, last_trans_nxt;
  logic [CountW-1:0] backend_counter_r, backend_counter_nxt;
  logic [CountW-1:0] ignored_r, ignored_nxt;
  logic [CountW-1:0] accepted_r, accepted_nxt;
  logic              stale;
  logic [ScanW:0]    scan_inc;
  logic [ScanW-1:0]  scan_sat;

  assign fire = ctl.valid && ctl.take;

  always_comb begin
    local_seen_nxt      = local_seen_r;
    local_counter_nxt   = local_counter_r;
    reseeding_nxt       = reseeding_r;
    scan_cnt_nxt        = scan_cnt_r;
    backend_seen_nxt    = backend_seen_r;
    last_session_nxt    = last_session_r;
    last_trans_nxt      = last_trans_r;
    backend_counter_nxt = backend_counter_r;
    ignored_nxt         = ignored_r;
    accepted_nxt        = accepted_r;
    stale               = 1'b0;
    scan_inc            = {1'b0, scan_cnt_r} + {{ScanW{1'b0}}, 1'b1};
    scan_sat            = (scan_inc > {1'b0, needed_r}) ? needed_r : scan_inc[ScanW-1:0];

    res.accepted       = 1'b0;
    res.reseed_started = 1'b0;
    res.reseed_done    = 1'b0;
    res.reason         = R_SCAN;
    res.fail_open      = reseeding_r;

    case (item.action)
      ACT_LOCAL: begin
        if (!local_seen_r) begin
          local_seen_nxt    = 1'b1;
          local_counter_nxt = item.reset_count;
          res.accepted      = 1'b1;
          res.reason        = R_INITIAL;
        end else if (item.reset_count == local_counter_r) begin
          res.accepted = 1'b1;
          res.reason   = R_SAME;
        end else if (item.reset_count < local_counter_r) begin
          res.reason = R_STALE_LOCAL;
        end else begin
          local_counter_nxt  = item.reset_count;
          scan_cnt_nxt       = '0;
          reseeding_nxt      = 1'b1;
          res.accepted       = 1'b1;
          res.reseed_started = 1'b1;
          res.reason         = R_LOCAL_CHANGED;
        end
        res.fail_open = (res.reason == R_INITIAL) ? 1'b0 : reseeding_nxt;
      end
      ACT_BACKEND: begin
        if (!item.was_applied) begin
          stale      = 1'b1;
          res.reason = R_NOT_APPLIED;
        end else if (backend_seen_r &&
                     ((item.session < last_session_r) ||
                      ((item.session == last_session_r) &&
                       ((item.transaction <= last_trans_r) ||
                        (item.reset_count < backend_counter_r))))) begin
          stale      = 1'b1;
          res.reason = R_STALE_BACKEND;
        end
        if (stale) begin
          ignored_nxt = (ignored_r == '1) ? ignored_r : ignored_r + 32'd1;
        end else begin
          backend_seen_nxt    = 1'b1;
          last_session_nxt    = item.session;
          last_trans_nxt      = item.transaction;
          backend_counter_nxt = item.reset_count;
          accepted_nxt        = (accepted_r == '1) ? accepted_r : accepted_r + 32'd1;
          res.accepted        = 1'b1;
          res.reason          = R_BACKEND_OK;
        end
      end
      ACT_SCAN: begin
        // count healthy scans while reseeding, saturating at the requirement
        if (reseeding_r && item.scan_healthy) begin
          scan_cnt_nxt = scan_sat;
          if (scan_sat >= needed_r) begin
            reseeding_nxt   = 1'b0;
            res.reseed_done = 1'b1;
          end
        end
        res.fail_open = reseeding_nxt;
      end
      default: begin
        res.fail_open = reseeding_r;
      end
    endcase

    res.ignored_total = ignored_nxt;
    res.backend_total = accepted_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      needed_r <= NeededScansReset;
    end else if (cfg_wr_en) begin
      needed_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_seen_r      <= 1'b0;
      local_counter_r   <= '0;
      reseeding_r       <= 1'b0;
      scan_cnt_r        <= '0;
      backend_seen_r    <= 1'b0;
      last_session_r    <= '0;
      last_trans_r      <= '0;
      backend_counter_r <= '0;
      ignored_r         <= '0;
      accepted_r        <= '0;
    end else if (fire) begin
      local_seen_r      <= local_seen_nxt;
      local_counter_r   <= local_counter_nxt;
      reseeding_r       <= reseeding_nxt;
      scan_cnt_r        <= scan_cnt_nxt;
      backend_seen_r    <= backend_seen_nxt;
      last_session_r    <= last_session_nxt;
      last_trans_r      <= last_trans_nxt;
      backend_counter_r <= backend_counter_nxt;
      ignored_r         <= ignored_nxt;
      accepted_r        <= accepted_nxt;
    end
  end

endmodule

// ===== hdl/erfg_out_stage.sv =====
module erfg_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  erfg_pkg::stage_ctl_t ctl,
  input  erfg_pkg::result_t res,
  output logic              space,
  output logic              out_valid,
  input  logic              out_ready,
  output erfg_pkg::result_t out_res
);
  import erfg_pkg::*;

  logic    valid_r, valid_nxt;
  result_t res_r;

  // room when empty or when the held result is taken this cycle
  assign space = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (ctl.valid && ctl.take) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.valid && ctl.take) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

// ===== hdl/epoch_reseed_freshness_guard.sv =====
// Channel  | Handshake            | Payload
// ---------+----------------------+-------------------------------------------------
// in       | in_valid / in_ready  | action, reset_count, session, transaction,
//          |                      | was_applied, scan_healthy
// out      | out_valid / out_ready| accepted, reseed_started, fail_open, reason,
//          |                      | reseed_done, ignored_total, backend_total
// cfg      | cfg_wr_en            | cfg_wr_data (needed_healthy_scans)
//
// One item per cycle sustained while out_ready stays high. An item lands in the input
// register when accepted; the decision logic fills the result register as the item
// moves on, raising out_valid. Guard state advances as each item moves on.
// Synchronous active-low reset clears all state and both totals; scan requirement is 1.
// With out_ready low the result register holds, the input register fills, and
// in_ready drops once both hold an item.
module epoch_reseed_freshness_guard (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [31:0] in_reset_count,
  input  logic [63:0] in_session,
  input  logic [63:0] in_transaction,
  input  logic        in_was_applied,
  input  logic        in_scan_healthy,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_accepted,
  output logic        out_reseed_started,
  output logic        out_fail_open,
  output logic [2:0]  out_reason,
  output logic        out_reseed_done,
  output logic [31:0] out_ignored_total,
  output logic [31:0] out_backend_total
);
  import erfg_pkg::*;

  item_t      in_item;
  item_t      held_item;
  stage_ctl_t ctl;
  result_t    res;
  result_t    out_res;
  logic       space;

  // pack the input ports into one item
  assign in_item.action       = in_action;
  assign in_item.reset_count  = in_reset_count;
  assign in_item.session      = in_session;
  assign in_item.transaction  = in_transaction;
  assign in_item.was_applied  = in_was_applied;
  assign in_item.scan_healthy = in_scan_healthy;

  // hold the item until the result register has room
  erfg_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .take     (space),
    .ctl      (ctl),
    .item     (held_item)
  );

  // decide the result and advance the guard state as the item moves on
  erfg_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .ctl         (ctl),
    .item        (held_item),
    .res         (res)
  );

  // hold the result until the consumer takes it
  erfg_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .res       (res),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  // unpack the result register onto the output ports
  assign out_accepted       = out_res.accepted;
  assign out_reseed_started = out_res.reseed_started;
  assign out_fail_open      = out_res.fail_open;
  assign out_reason         = out_res.reason;
  assign out_reseed_done    = out_res.reseed_done;
  assign out_ignored_total  = out_res.ignored_total;
  assign out_backend_total  = out_res.backend_total;

endmodule

// ===== hdl/erfg_checker.sv =====
module erfg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_accepted,
  input logic        out_reseed_started,
  input logic        out_fail_open,
  input logic [2:0]  out_reason,
  input logic        out_reseed_done,
  input logic [31:0] out_ignored_total,
  input logic [31:0] out_backend_total
);
  import erfg_pkg::*;

  // a stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_reason) &&
      $stable(out_ignored_total) && $stable(out_backend_total))
    else $error("stalled result changed");

  // a new reseed phase comes only from a newer local counter
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_reseed_started |->
      out_reason == R_LOCAL_CHANGED && out_fail_open && out_accepted)
    else $error("reseed start with wrong flags");

  // finishing reseeding is a scan result that leaves the block ready
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_reseed_done |->
      out_reason == R_SCAN && !out_fail_open && !out_accepted)
    else $error("reseed done with wrong flags");

  // backend verdicts agree with the accept flag
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_reason == R_NOT_APPLIED || out_reason == R_STALE_BACKEND ||
      out_reason == R_BACKEND_OK) |->
      out_accepted == (out_reason == R_BACKEND_OK) && !out_reseed_started)
    else $error("backend verdict and accept flag disagree");

endmodule

bind epoch_reseed_freshness_guard erfg_checker u_erfg_checker (.*);

// ===== sim/tb_epoch_reseed_freshness_guard.sv =====
`timescale 1ns / 100ps

module tb_epoch_reseed_freshness_guard;
  import erfg_pkg::*;

  // Action code that the block leaves unused; it must change nothing.
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam int NUM_PHASES      = 7;
  localparam int ITEMS_PER_PHASE = 215;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int PRINT_CAP       = 40;

  // Scan requirement and idle odds (percent) per random phase. The zero entry
  // must behave like one, the 255 entry builds a long count that the smaller
  // value after it cuts short, and the last phase runs without any gaps.
  localparam logic [7:0] PHASE_SCANS [NUM_PHASES] = '{8'd0, 8'd255, 8'd2, 8'd1, 8'd7,
                                                      8'd128, 8'd3};
  localparam int PHASE_IDLE [NUM_PHASES] = '{25, 35, 0, 15, 40, 20, 0};

  typedef struct {
    item_t   ev;
    bit      typed;
    result_t want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [7:0]  cfg_wr_data;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_action;
  logic [31:0] in_reset_count;
  logic [63:0] in_session;
  logic [63:0] in_transaction;
  logic        in_was_applied;
  logic        in_scan_healthy;
  logic        out_valid;
  logic        out_ready = 1'b1;
  logic        out_accepted;
  logic        out_reseed_started;
  logic        out_fail_open;
  logic [2:0]  out_reason;
  logic        out_reseed_done;
  logic [31:0] out_ignored_total;
  logic [31:0] out_backend_total;

  // Shadow copy of the guard state, advanced once per accepted item.
  logic [7:0]  scans_needed;
  logic        seen_local;
  logic [31:0] local_rc;
  logic        in_reseed;
  logic [7:0]  healthy_run;
  logic        seen_backend;
  logic [63:0] top_session;
  logic [63:0] top_transaction;
  logic [31:0] top_rc;
  logic [31:0] ignored_tally;
  logic [31:0] accepted_tally;

  result_t   expected_results [$];
  stim_row_t stim_table [$];
  int        mismatch_count = 0;
  int        idle_pct = 20;
  int        stall_left = 0;
  int        quiet_cycles = 0;

  epoch_reseed_freshness_guard dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_action          (in_action),
    .in_reset_count     (in_reset_count),
    .in_session         (in_session),
    .in_transaction     (in_transaction),
    .in_was_applied     (in_was_applied),
    .in_scan_healthy    (in_scan_healthy),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_accepted       (out_accepted),
    .out_reseed_started (out_reseed_started),
    .out_fail_open      (out_fail_open),
    .out_reason         (out_reason),
    .out_reseed_done    (out_reseed_done),
    .out_ignored_total  (out_ignored_total),
    .out_backend_total  (out_backend_total)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic log_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) begin
      $display("[%0t] MISMATCH %s", $realtime, msg);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      log_mismatch($sformatf("%s: got 0x%0h, want 0x%0h", name, got, want));
    end
  endtask

  function automatic item_t mk_item(input logic [1:0] act, input logic [31:0] rc,
                                    input logic [63:0] sess, input logic [63:0] trans,
                                    input logic applied, input logic healthy);
    item_t ev;
    ev.action       = act;
    ev.reset_count  = rc;
    ev.session      = sess;
    ev.transaction  = trans;
    ev.was_applied  = applied;
    ev.scan_healthy = healthy;
    return ev;
  endfunction

  function automatic result_t mk_result(input logic acc, input logic started,
                                        input logic fopen, input reason_t why,
                                        input logic done, input logic [31:0] ign,
                                        input logic [31:0] tot);
    result_t r;
    r.accepted       = acc;
    r.reseed_started = started;
    r.fail_open      = fopen;
    r.reason         = why;
    r.reseed_done    = done;
    r.ignored_total  = ign;
    r.backend_total  = tot;
    return r;
  endfunction

  // Decide one event against the shadow state and advance that state.
  function automatic result_t judge_event(input item_t ev);
    result_t    r;
    logic       stale;
    logic [8:0] next_run;
    r = '0;
    r.reason = R_SCAN;
    case (ev.action)
      ACT_LOCAL: begin
        if (!seen_local) begin
          seen_local = 1'b1;
          local_rc   = ev.reset_count;
          r.accepted = 1'b1;
          r.reason   = R_INITIAL;
        end else if (ev.reset_count == local_rc) begin
          r.accepted = 1'b1;
          r.reason   = R_SAME;
        end else if (ev.reset_count < local_rc) begin
          r.reason = R_STALE_LOCAL;
        end else begin
          // Newer counter: restart reseeding from an empty scan count.
          local_rc         = ev.reset_count;
          healthy_run      = '0;
          in_reseed        = 1'b1;
          r.accepted       = 1'b1;
          r.reseed_started = 1'b1;
          r.reason         = R_LOCAL_CHANGED;
        end
        r.fail_open = (r.reason == R_INITIAL) ? 1'b0 : in_reseed;
      end
      ACT_BACKEND: begin
        stale = 1'b0;
        if (!ev.was_applied) begin
          stale    = 1'b1;
          r.reason = R_NOT_APPLIED;
        end else if (seen_backend) begin
          if (ev.session < top_session ||
              (ev.session == top_session &&
               (ev.transaction <= top_transaction || ev.reset_count < top_rc))) begin
            stale    = 1'b1;
            r.reason = R_STALE_BACKEND;
          end
        end
        if (stale) begin
          if (ignored_tally != '1) ignored_tally++;
        end else begin
          seen_backend    = 1'b1;
          top_session     = ev.session;
          top_transaction = ev.transaction;
          top_rc          = ev.reset_count;
          if (accepted_tally != '1) accepted_tally++;
          r.accepted = 1'b1;
          r.reason   = R_BACKEND_OK;
        end
        r.fail_open = in_reseed;
      end
      default: begin
        // Healthy scans count only while reseeding; the count never passes
        // the requirement, and a zero requirement ends on the first healthy scan.
        if (ev.action == ACT_SCAN && in_reseed && ev.scan_healthy) begin
          next_run = {1'b0, healthy_run} + 9'd1;
          if (next_run > {1'b0, scans_needed}) next_run = {1'b0, scans_needed};
          healthy_run = next_run[7:0];
          if (healthy_run >= scans_needed) begin
            in_reseed     = 1'b0;
            r.reseed_done = 1'b1;
          end
        end
        r.fail_open = in_reseed;
      end
    endcase
    r.ignored_total = ignored_tally;
    r.backend_total = accepted_tally;
    return r;
  endfunction

  // Draw mostly plausible events built on the current state, plus some noise.
  function automatic item_t draw_event();
    item_t ev;
    int    pick;
    ev = mk_item(2'($urandom), $urandom, {$urandom, $urandom}, {$urandom, $urandom},
                 1'($urandom), 1'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      ev.action = ACT_LOCAL;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: ev.reset_count = local_rc;
        4, 5, 6:    ev.reset_count = local_rc + 32'($urandom_range(1, 3));
        7:          ev.reset_count = local_rc - 32'($urandom_range(1, 3));
        default:    ev.reset_count = $urandom;
      endcase
    end else if (pick < 65) begin
      ev.action      = ACT_BACKEND;
      ev.was_applied = ($urandom_range(0, 9) != 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          ev.session     = top_session;
          ev.transaction = top_transaction + 64'($urandom_range(1, 3));
          ev.reset_count = top_rc + 32'($urandom_range(0, 2));
        end
        5: ev.session = top_session + 64'd1;
        6: begin
          ev.session     = top_session;
          ev.transaction = top_transaction - 64'($urandom_range(0, 2));
          ev.reset_count = top_rc + 32'd1;
        end
        7: begin
          ev.session     = top_session;
          ev.transaction = top_transaction + 64'd1;
          ev.reset_count = top_rc - 32'($urandom_range(1, 3));
        end
        8: ev.session = top_session - 64'($urandom_range(1, 3));
        default: ;
      endcase
    end else if (pick < 97) begin
      ev.action       = ACT_SCAN;
      ev.scan_healthy = ($urandom_range(0, 4) != 0);
    end else begin
      ev.action = ACT_UNUSED;
    end
    return ev;
  endfunction

  // Present one item, hold it until accepted, then record what it should give.
  task automatic offer_item(input item_t ev, input bit typed, input result_t want);
    result_t calc;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_action       <= ev.action;
    in_reset_count  <= ev.reset_count;
    in_session      <= ev.session;
    in_transaction  <= ev.transaction;
    in_was_applied  <= ev.was_applied;
    in_scan_healthy <= ev.scan_healthy;
    do @(posedge clk); while (!in_ready);
    // Advance the shadow state even where the row carries its own answer.
    calc = judge_event(ev);
    expected_results.push_back(typed ? want : calc);
  endtask

  // Directed rows: extremes of every field, every action and reason, the
  // unused action code, and backend ordering corner cases. The local counter
  // stays low here so later random items can still start new reseed phases.
  initial begin
    stim_table.push_back('{mk_item(ACT_SCAN, '0, '0, '0, 1'b0, 1'b1), 1'b1,
                           mk_result(0, 0, 0, R_SCAN, 0, 0, 0)});
    stim_table.push_back('{mk_item(ACT_UNUSED, '1, '1, '1, 1'b1, 1'b1), 1'b1,
                           mk_result(0, 0, 0, R_SCAN, 0, 0, 0)});
    stim_table.push_back('{mk_item(ACT_LOCAL, 32'd5, '0, '0, 1'b0, 1'b0), 1'b1,
                           mk_result(1, 0, 0, R_INITIAL, 0, 0, 0)});
    stim_table.push_back('{mk_item(ACT_LOCAL, 32'd5, '0, '0, 1'b0, 1'b0), 1'b1,
                           mk_result(1, 0, 0, R_SAME, 0, 0, 0)});
    stim_table.push_back('{mk_item(ACT_LOCAL, '0, '0, '0, 1'b0, 1'b0), 1'b1,
                           mk_result(0, 0, 0, R_STALE_LOCAL, 0, 0, 0)});
    stim_table.push_back('{mk_item(ACT_LOCAL, 32'd9, '0, '0, 1'b0, 1'b0), 1'b1,
                           mk_result(1, 1, 1, R_LOCAL_CHANGED, 0, 0, 0)});
    stim_table.push_back('{mk_item(ACT_SCAN, '0, '0, '0, 1'b0, 1'b0), 1'b1,
                           mk_result(0, 0, 1, R_SCAN, 0, 0, 0)});
    stim_table.push_back('{mk_item(ACT_UNUSED, '0, '0, '0, 1'b0, 1'b1), 1'b1,
                           mk_result(0, 0, 1, R_SCAN, 0, 0, 0)});
    stim_table.push_back('{mk_item(ACT_BACKEND, '1, '1, '1, 1'b0, 1'b0), 1'b1,
                           mk_result(0, 0, 1, R_NOT_APPLIED, 0, 1, 0)});
    stim_table.push_back('{mk_item(ACT_LOCAL, 32'd9, '0, '0, 1'b0, 1'b0), 1'b1,
                           mk_result(1, 0, 1, R_SAME, 0, 1, 0)});
    stim_table.push_back('{mk_item(ACT_SCAN, '0, '0, '0, 1'b0, 1'b1), 1'b1,
                           mk_result(0, 0, 0, R_SCAN, 1, 1, 0)});
    stim_table.push_back('{mk_item(ACT_BACKEND, '0, '0, '0, 1'b1, 1'b0), 1'b1,
                           mk_result(1, 0, 0, R_BACKEND_OK, 0, 1, 1)});
    stim_table.push_back('{mk_item(ACT_BACKEND, '0, '0, '0, 1'b1, 1'b0), 1'b1,
                           mk_result(0, 0, 0, R_STALE_BACKEND, 0, 2, 1)});
    stim_table.push_back('{mk_item(ACT_BACKEND, '0, '0, 64'd1, 1'b1, 1'b0), 1'b1,
                           mk_result(1, 0, 0, R_BACKEND_OK, 0, 2, 2)});
    stim_table.push_back('{mk_item(ACT_BACKEND, '1, '0, 64'd2, 1'b1, 1'b0), 1'b1,
                           mk_result(1, 0, 0, R_BACKEND_OK, 0, 2, 3)});
    stim_table.push_back('{mk_item(ACT_BACKEND, 32'd5, '0, 64'd3, 1'b1, 1'b0), 1'b1,
                           mk_result(0, 0, 0, R_STALE_BACKEND, 0, 3, 3)});
    stim_table.push_back('{mk_item(ACT_BACKEND, '0, '1, '0, 1'b1, 1'b0), 1'b1,
                           mk_result(1, 0, 0, R_BACKEND_OK, 0, 3, 4)});
    stim_table.push_back('{mk_item(ACT_BACKEND, '1, 64'd1, '1, 1'b1, 1'b0), 1'b1,
                           mk_result(0, 0, 0, R_STALE_BACKEND, 0, 4, 4)});
    stim_table.push_back('{mk_item(ACT_BACKEND, '1, '1, '1, 1'b1, 1'b0), 1'b1,
                           mk_result(1, 0, 0, R_BACKEND_OK, 0, 4, 5)});
    stim_table.push_back('{mk_item(ACT_BACKEND, '1, '1, '1, 1'b1, 1'b1), 1'b1,
                           mk_result(0, 0, 0, R_STALE_BACKEND, 0, 5, 5)});
    stim_table.push_back('{mk_item(ACT_SCAN, '1, '1, '1, 1'b1, 1'b1), 1'b1,
                           mk_result(0, 0, 0, R_SCAN, 0, 5, 5)});
  end

  // Stimulus: reset, directed rows, then random phases at several scan
  // requirements, each started only once the block has drained.
  initial begin
    rst_n           <= 1'b0;
    cfg_wr_en       <= 1'b0;
    cfg_wr_data     <= '0;
    in_valid        <= 1'b0;
    in_action       <= ACT_LOCAL;
    in_reset_count  <= '0;
    in_session      <= '0;
    in_transaction  <= '0;
    in_was_applied  <= 1'b0;
    in_scan_healthy <= 1'b0;
    scans_needed    = NeededScansReset;
    seen_local      = 1'b0;
    local_rc        = '0;
    in_reseed       = 1'b0;
    healthy_run     = '0;
    seen_backend    = 1'b0;
    top_session     = '0;
    top_transaction = '0;
    top_rc          = '0;
    ignored_tally   = '0;
    accepted_tally  = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (stim_table[i]) begin
      offer_item(stim_table[i].ev, stim_table[i].typed, stim_table[i].want);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      // Drop valid and drain before touching the scan requirement.
      in_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clk);
      cfg_wr_en   <= 1'b1;
      cfg_wr_data <= PHASE_SCANS[p];
      @(posedge clk);
      cfg_wr_en    <= 1'b0;
      scans_needed = PHASE_SCANS[p];
      idle_pct     = PHASE_IDLE[p];
      repeat (ITEMS_PER_PHASE) offer_item(draw_event(), 1'b0, '0);
    end

    // Drain, then wait past the pipeline depth to catch strays.
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (expected_results.size() != 0) begin
      log_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    end
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Result side: check each accepted result against the oldest expectation,
  // then stall out_ready in random bursts.
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        log_mismatch($sformatf("unexpected result, reason %0d", out_reason));
      end else begin
        want = expected_results.pop_front();
        check_field("accepted", 32'(out_accepted), 32'(want.accepted));
        check_field("reseed_started", 32'(out_reseed_started), 32'(want.reseed_started));
        check_field("fail_open", 32'(out_fail_open), 32'(want.fail_open));
        check_field("reason", 32'(out_reason), 32'(want.reason));
        check_field("reseed_done", 32'(out_reseed_done), 32'(want.reseed_done));
        check_field("ignored_total", out_ignored_total, want.ignored_total);
        check_field("backend_total", out_backend_total, want.backend_total);
      end
    end
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= (stall_left == 1);
    end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      stall_left <= $urandom_range(1, 7);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog: end the run if neither channel moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// ===== files.f =====
hdl/erfg_pkg.sv
hdl/erfg_in_stage.sv
hdl/erfg_core.sv
hdl/erfg_out_stage.sv
hdl/epoch_reseed_freshness_guard.sv
hdl/erfg_checker.sv
sim/tb_epoch_reseed_freshness_guard.sv
